@@ sv/bmp_24bit_stream_encoder_defines.svh @@
// Assertion macros shared by the encoder modules.
// Each expects i_clk and i_rst_n in scope.
`ifndef BMP_24BIT_STREAM_ENCODER_DEFINES_SVH
`define BMP_24BIT_STREAM_ENCODER_DEFINES_SVH

// Same-cycle implication.
`define BMPE_ASSERT_IMPL(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("bmpe assertion failed");

// Next-cycle implication.
`define BMPE_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("bmpe assertion failed");

`endif

@@ sv/bmpe_pkg.sv @@
package bmpe_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int SIZE_W   = 13;   // width/height registers
    localparam int CNT_W    = 12;   // column/row counters
    localparam int STRIDE_W = 14;   // row stride in bytes
    localparam int IMG_W    = 26;   // image size and file size
    localparam int IDX_W    = 6;    // byte index within a request
    localparam int CFG_IDX_W = 2;

    localparam int HDR_LEN  = 54;
    localparam int INFO_LEN = 40;
    localparam int BPP      = 24;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    localparam logic [7:0] CHAR_B = 8'h42;
    localparam logic [7:0] CHAR_M = 8'h4D;

    typedef enum logic {
        CMD_HEADER,
        CMD_PIXEL
    } t_cmd_kind;

    // One queued job for the byte emitter.
    typedef struct packed {
        t_cmd_kind             kind;
        logic [SIZE_W-1:0]     width;
        logic [SIZE_W-1:0]     height;
        logic [STRIDE_W-1:0]   stride;
        logic [7:0]            blue;
        logic [7:0]            green;
        logic [7:0]            red;
        logic [1:0]            pad;
        logic                  frame_end;
    } t_cmd;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

    // Header byte at offset idx, little endian fields.
    function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0]  idx,
                                            input logic [SIZE_W-1:0] w,
                                            input logic [SIZE_W-1:0] h,
                                            input logic [IMG_W-1:0]  img,
                                            input logic [IMG_W-1:0]  fsize);
        logic [7:0] b;
        b = 8'h00;
        case (idx)
            6'd0:    b = CHAR_B;
            6'd1:    b = CHAR_M;
            6'd2:    b = fsize[7:0];
            6'd3:    b = fsize[15:8];
            6'd4:    b = fsize[23:16];
            6'd5:    b = {6'b0, fsize[25:24]};
            6'd10:   b = 8'(HDR_LEN);
            6'd14:   b = 8'(INFO_LEN);
            6'd18:   b = w[7:0];
            6'd19:   b = {3'b0, w[12:8]};
            6'd22:   b = h[7:0];
            6'd23:   b = {3'b0, h[12:8]};
            6'd26:   b = 8'd1;
            6'd28:   b = 8'(BPP);
            6'd34:   b = img[7:0];
            6'd35:   b = img[15:8];
            6'd36:   b = img[23:16];
            6'd37:   b = {6'b0, img[25:24]};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ sv/bmpe_front.sv @@
// Request side: config registers, frame tracking, command build.
module bmpe_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bmpe_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bmpe_pkg::SIZE_W-1:0]        i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_req_type,
    input  logic [7:0]                         i_red,
    input  logic [7:0]                         i_green,
    input  logic [7:0]                         i_blue,
    input  logic                               i_q_full,
    output logic                               o_q_push,
    output bmpe_pkg::t_cmd                     o_q_cmd
);

    logic [bmpe_pkg::SIZE_W-1:0]   r_frame_width,  n_frame_width;
    logic [bmpe_pkg::SIZE_W-1:0]   r_frame_height, n_frame_height;
    logic [bmpe_pkg::SIZE_W-1:0]   r_cur_w, n_cur_w;
    logic [bmpe_pkg::SIZE_W-1:0]   r_cur_h, n_cur_h;
    logic [bmpe_pkg::CNT_W-1:0]    r_col, n_col;
    logic [bmpe_pkg::CNT_W-1:0]    r_row, n_row;
    logic                          r_active, n_active;

    logic                          accept;
    logic                          row_end;
    logic                          frame_end;
    logic [bmpe_pkg::SIZE_W-1:0]   w_clamped;
    logic [bmpe_pkg::SIZE_W-1:0]   h_clamped;
    logic [bmpe_pkg::STRIDE_W-1:0] w_ext;
    logic [bmpe_pkg::STRIDE_W-1:0] stride_new;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_full;
    assign accept      = i_in_valid && !o_in_stall;

    assign w_clamped  = bmpe_pkg::clamp_size(r_frame_width,
                                             bmpe_pkg::SIZE_W'(bmpe_pkg::MAX_WIDTH));
    assign h_clamped  = bmpe_pkg::clamp_size(r_frame_height,
                                             bmpe_pkg::SIZE_W'(bmpe_pkg::MAX_HEIGHT));
    // stride = 3w rounded up to four = 3w + (w mod 4)
    assign w_ext      = {1'b0, w_clamped};
    assign stride_new = (w_ext << 1) + w_ext
                      + {{(bmpe_pkg::STRIDE_W-2){1'b0}}, w_clamped[1:0]};

    assign row_end   = ({1'b0, r_col} + 1'b1) >= r_cur_w;
    assign frame_end = row_end && (({1'b0, r_row} + 1'b1) >= r_cur_h);

    always_comb begin
        o_q_cmd.kind      = (i_req_type == bmpe_pkg::REQ_START) ? bmpe_pkg::CMD_HEADER
                                                                : bmpe_pkg::CMD_PIXEL;
        o_q_cmd.width     = w_clamped;
        o_q_cmd.height    = h_clamped;
        o_q_cmd.stride    = stride_new;
        o_q_cmd.blue      = i_blue;
        o_q_cmd.green     = i_green;
        o_q_cmd.red       = i_red;
        o_q_cmd.pad       = row_end ? r_cur_w[1:0] : 2'd0;
        o_q_cmd.frame_end = frame_end;
    end

    // pixels outside a frame are taken and dropped
    assign o_q_push = accept && ((i_req_type == bmpe_pkg::REQ_START) || r_active);

    always_comb begin
        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        n_cur_w        = r_cur_w;
        n_cur_h        = r_cur_h;
        n_col          = r_col;
        n_row          = r_row;
        n_active       = r_active;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                bmpe_pkg::REG_FRAME_WIDTH:  n_frame_width  = i_cfg_data;
                bmpe_pkg::REG_FRAME_HEIGHT: n_frame_height = i_cfg_data;
                default: ;
            endcase
        end

        if (accept) begin
            if (i_req_type == bmpe_pkg::REQ_START) begin
                n_cur_w  = w_clamped;
                n_cur_h  = h_clamped;
                n_col    = '0;
                n_row    = '0;
                n_active = 1'b1;
            end else if (r_active) begin
                if (frame_end) begin
                    n_active = 1'b0;
                    n_col    = '0;
                    n_row    = '0;
                end else if (row_end) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bmpe_pkg::SIZE_W'(1);
            r_frame_height <= bmpe_pkg::SIZE_W'(1);
            r_cur_w        <= bmpe_pkg::SIZE_W'(1);
            r_cur_h        <= bmpe_pkg::SIZE_W'(1);
            r_col          <= '0;
            r_row          <= '0;
            r_active       <= 1'b0;
        end else begin
            r_frame_width  <= n_frame_width;
            r_frame_height <= n_frame_height;
            r_cur_w        <= n_cur_w;
            r_cur_h        <= n_cur_h;
            r_col          <= n_col;
            r_row          <= n_row;
            r_active       <= n_active;
        end
    end

endmodule

@@ sv/bmpe_fifo.sv @@
`include "bmp_24bit_stream_encoder_defines.svh"

// Small command queue between front and back.
module bmpe_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bmpe_pkg::t_cmd  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output bmpe_pkg::t_cmd  o_data,
    output logic            o_empty
);

    bmpe_pkg::t_cmd                   r_mem [bmpe_pkg::FIFO_DEPTH];
    logic [bmpe_pkg::FIFO_PTR_W-1:0]  r_wr, n_wr;
    logic [bmpe_pkg::FIFO_PTR_W-1:0]  r_rd, n_rd;
    logic [bmpe_pkg::FIFO_CNT_W-1:0]  r_count, n_count;

    assign o_full  = r_count == bmpe_pkg::FIFO_CNT_W'(bmpe_pkg::FIFO_DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = i_push ? r_wr + 1'b1 : r_wr;
        n_rd    = i_pop  ? r_rd + 1'b1 : r_rd;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `BMPE_ASSERT_IMPL(a_no_overflow, i_push, !o_full)
    `BMPE_ASSERT_IMPL(a_no_underflow, i_pop, !o_empty)
    `BMPE_ASSERT_IMPL(a_count_range, 1'b1, r_count <= bmpe_pkg::FIFO_CNT_W'(bmpe_pkg::FIFO_DEPTH))

endmodule

@@ sv/bmpe_back.sv @@
`include "bmp_24bit_stream_encoder_defines.svh"

// Byte emitter: walks one command into the output register, a byte per cycle unless i_out_stall holds it.
module bmpe_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  bmpe_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run,
    output logic            o_end_of_frame
);

    localparam int PROD_W = bmpe_pkg::STRIDE_W + bmpe_pkg::SIZE_W;

    bmpe_pkg::t_cmd                 r_cmd;
    logic                           r_busy;
    logic [bmpe_pkg::IDX_W-1:0]     r_idx;
    logic [bmpe_pkg::IMG_W-1:0]     r_img;
    logic [bmpe_pkg::IMG_W-1:0]     r_fsize;
    logic                           r_ovalid;
    logic [7:0]                     r_obyte;
    logic                           r_olast;
    logic                           r_oeof;

    logic [PROD_W-1:0]              prod;
    logic [2:0]                     pix_total;
    logic [7:0]                     cur_byte;
    logic                           cur_last;
    logic                           cur_eof;
    logic                           load;
    logic                           done;

    // image size is registered from the latched command, file size from the image
    // size; file size is first read at byte offset 2, image size at offset 34
    assign prod      = PROD_W'(r_cmd.stride) * PROD_W'(r_cmd.height);
    assign pix_total = 3'd3 + {1'b0, r_cmd.pad};

    always_comb begin
        cur_byte = 8'h00;
        cur_last = 1'b0;
        cur_eof  = 1'b0;
        case (r_cmd.kind)
            bmpe_pkg::CMD_HEADER: begin
                cur_byte = bmpe_pkg::hdr_byte(r_idx, r_cmd.width, r_cmd.height,
                                              r_img, r_fsize);
                cur_last = r_idx == bmpe_pkg::IDX_W'(bmpe_pkg::HDR_LEN - 1);
            end
            bmpe_pkg::CMD_PIXEL: begin
                case (r_idx)
                    6'd0:    cur_byte = r_cmd.blue;
                    6'd1:    cur_byte = r_cmd.green;
                    6'd2:    cur_byte = r_cmd.red;
                    default: cur_byte = 8'h00;
                endcase
                cur_last = r_idx == {3'b0, pix_total - 3'd1};
                cur_eof  = cur_last && r_cmd.frame_end;
            end
            default: ;
        endcase
    end

    assign load  = r_busy && (!r_ovalid || !i_out_stall);
    assign done  = load && cur_last;
    assign o_pop = i_cmd_valid && (!r_busy || done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (done) begin
                r_busy <= 1'b0;
            end else if (load) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        r_img   <= prod[bmpe_pkg::IMG_W-1:0];
        r_fsize <= r_img + bmpe_pkg::IMG_W'(bmpe_pkg::HDR_LEN);
        if (load) begin
            r_obyte <= cur_byte;
            r_olast <= cur_last;
            r_oeof  <= cur_eof;
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_out_byte     = r_obyte;
    assign o_last_of_run  = r_olast;
    assign o_end_of_frame = r_oeof;

    `BMPE_ASSERT_IMPL(a_eof_is_last, r_ovalid && r_oeof, r_olast)
    `BMPE_ASSERT_IMPL(a_hdr_idx_range, r_busy && (r_cmd.kind == bmpe_pkg::CMD_HEADER),
                      r_idx < bmpe_pkg::IDX_W'(bmpe_pkg::HDR_LEN))
    `BMPE_ASSERT_NEXT(a_idle_after_done, done && !o_pop, !r_busy)

endmodule

@@ sv/bmp_24bit_stream_encoder.sv @@
// 24-bit uncompressed BMP stream encoder.
// Input channel (i_in_valid / o_in_stall): a start request (req_type 0)
// latches the configured width and height, clamped to 1..4096, and produces
// the 54-byte file header; each pixel request (req_type 1, bottom row first)
// produces blue, green, red, plus zero padding on the last pixel of a row.
// Alpha is taken and dropped; pixels outside an open frame produce nothing.
// Output channel (o_out_valid / i_out_stall): one file byte per transfer, with
// last_of_run on the final byte of each request and end_of_frame on the last
// byte of the file. Config writes (i_cfg_valid / o_cfg_ready, always ready)
// take effect at the next start request.
// Throughput: one byte per cycle at the output register while i_out_stall is
// low, so a pixel gives three bytes (up to six at a row end) and a header 54;
// a four-deep command queue lets requests be taken while earlier bytes still
// drain. Reset (synchronous, active low) closes any frame, empties the queue
// and sets both size registers to 1. While i_out_stall is high a valid
// output byte holds and the emitter waits; the input stalls only once the
// queue fills.
module bmp_24bit_stream_encoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bmpe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bmpe_pkg::SIZE_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_req_type,
    input  logic [7:0]                      i_red,
    input  logic [7:0]                      i_green,
    input  logic [7:0]                      i_blue,
    input  logic [7:0]                      i_alpha,   // not stored
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_out_byte,
    output logic                            o_last_of_run,
    output logic                            o_end_of_frame
);

    bmpe_pkg::t_cmd q_in_cmd;
    bmpe_pkg::t_cmd q_out_cmd;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;

    // front: config, frame/row/column tracking, request classification
    bmpe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in_cmd)
    );

    // decouples request acceptance from byte emission
    bmpe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out_cmd),
        .o_empty (q_empty)
    );

    // back: header/pixel byte sequencing into the output register
    bmpe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (!q_empty),
        .i_cmd          (q_out_cmd),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_run  (o_last_of_run),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule
